>>> src/alra_pkg.sv
// Package: shared types and constants of the addressed link receive and ack engine.
`default_nettype none
package alra_pkg;

   localparam int FIELD_BYTES = 4;
   localparam int FIELD_CNT_W = (FIELD_BYTES > 1) ? $clog2(FIELD_BYTES) : 1;
   localparam int FIELD_W     = 32;
   localparam int CSR_DATA_W  = 16;
   localparam int CSR_INDEX_W = 2;
   localparam logic [7:0] TIMEOUT_RESET  = 8'd10;
   localparam logic [15:0] CAPACITY_RESET = 16'hFFFF;

   typedef enum logic [1:0] {
      REQ_BYTE = 2'd0,
      REQ_TICK = 2'd1,
      REQ_ARM  = 2'd2,
      REQ_NONE = 2'd3
   } req_kind_type;

   typedef enum logic [2:0] {
      EV_DATA     = 3'd0,
      EV_SEND_ACK = 3'd1,
      EV_ACK_OK   = 3'd2,
      EV_RETX     = 3'd3,
      EV_OVERFLOW = 3'd4,
      EV_TIMEOUT  = 3'd5
   } event_kind_type;

   typedef enum logic [2:0] {
      PH_HUNT    = 3'd0,
      PH_ID      = 3'd1,
      PH_LEN     = 3'd2,
      PH_PAYLOAD = 3'd3,
      PH_ACK     = 3'd4
   } phase_type;

   typedef enum logic [1:0] {
      CSR_MY_ADDRESS      = 2'd0,
      CSR_AUTO_RETRANSMIT = 2'd1,
      CSR_RX_CAPACITY     = 2'd2,
      CSR_TIMEOUT_TICKS   = 2'd3
   } csr_index_type;

endpackage
`default_nettype wire

>>> src/alra_if.sv
// Interfaces: request and response channels of the receive and ack engine.
`default_nettype none
interface alra_req_if;
   logic                        valid;
   logic                        ready;
   logic [1:0]                  req_type;
   logic [7:0]                  line_byte;
   logic                        address_mark;

   modport source (output valid, output req_type, output line_byte,
                   output address_mark, input ready);
   modport sink   (input valid, input req_type, input line_byte,
                   input address_mark, output ready);
endinterface

interface alra_rsp_if;
   logic                        valid;
   logic                        ready;
   alra_pkg::event_kind_type    event_kind;
   logic [7:0]                  data_byte;
   logic                        last_byte;
   logic [alra_pkg::FIELD_W-1:0] ack_value;

   modport source (output valid, output event_kind, output data_byte,
                   output last_byte, output ack_value, input ready);
   modport sink   (input valid, input event_kind, input data_byte,
                   input last_byte, input ack_value, output ready);
endinterface
`default_nettype wire

>>> src/addressed_link_receive_ack.sv
// Top level: addressed serial link receive engine with acknowledge handling.
//
//   Channel   Direction  Carries
//   req_ch    in         line byte, timer tick or arm-ack-wait request
//   rsp_ch    out        payload byte, send ack, ack accepted, retransmit,
//                        overflow or timeout event
//   csr_*     in         write-only configuration registers
//
// One request is taken every cycle unless the result register is blocked;
// its single optional result appears in the result register on the following cycle.
// The request ready is low only while the result register holds an event
// that the consumer has not yet taken, so a stall on the response side
// holds off requests for exactly as long as it lasts.
// Reset is synchronous and active high; it returns the engine to address
// hunting in general mode and loads the register defaults.
`default_nettype none
module addressed_link_receive_ack (
   input  wire logic                              clock,
   input  wire logic                              reset,
   alra_req_if.sink                               req_ch,
   alra_rsp_if.source                             rsp_ch,
   input  wire logic                              csr_we,
   input  wire logic [alra_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [alra_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   // Configuration registers.
   logic [7:0]                      my_address_ff;
   logic                            auto_retransmit_ff;
   logic [15:0]                     rx_capacity_ff;
   logic [7:0]                      timeout_ticks_ff;

   // Framing state.
   alra_pkg::phase_type             phase_ff, phase_in;
   logic                            ack_wait_ff, ack_wait_in;
   logic [alra_pkg::FIELD_CNT_W-1:0] field_cnt_ff, field_cnt_in;
   logic [alra_pkg::FIELD_W-1:0]    rx_id_ff, rx_id_in;
   logic [alra_pkg::FIELD_W-1:0]    rx_length_ff, rx_length_in;
   logic [alra_pkg::FIELD_W-1:0]    payload_left_ff, payload_left_in;
   logic [7:0]                      idle_ticks_ff, idle_ticks_in;
   logic [alra_pkg::FIELD_W-1:0]    tx_id_ff, tx_id_in;

   // Result register.
   logic                            rsp_valid_ff, rsp_valid_in;
   alra_pkg::event_kind_type        rsp_kind_ff, rsp_kind_in;
   logic [7:0]                      rsp_data_ff, rsp_data_in;
   logic                            rsp_last_ff, rsp_last_in;
   logic [alra_pkg::FIELD_W-1:0]    rsp_ack_ff, rsp_ack_in;

   // Result of the request being accepted this cycle.
   logic                            res_valid;
   alra_pkg::event_kind_type        res_kind;
   logic [7:0]                      res_data;
   logic                            res_last;
   logic [alra_pkg::FIELD_W-1:0]    res_ack;

   logic                            req_accept;
   alra_pkg::req_kind_type          req_kind;
   logic                            field_full;
   logic [alra_pkg::FIELD_W-1:0]    byte_shifted;
   logic [alra_pkg::FIELD_W-1:0]    rx_id_acc;
   logic [alra_pkg::FIELD_W-1:0]    rx_length_acc;
   logic [alra_pkg::FIELD_W-1:0]    rx_id_plus1;
   logic [alra_pkg::FIELD_W-1:0]    tx_id_plus1;
   logic [7:0]                      idle_sat;

   // A request may enter whenever the result register is free or is
   // being emptied in this very cycle.
   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign req_accept   = req_ch.valid && req_ch.ready;
   assign req_kind     = alra_pkg::req_kind_type'(req_ch.req_type);

   // Little-endian field gathering: each byte lands at the lane chosen by
   // the field byte counter. A field holds four bytes; after the fourth the
   // counter wraps and the phase moves on.
   assign byte_shifted  = {{(alra_pkg::FIELD_W-8){1'b0}}, req_ch.line_byte}
                          << {field_cnt_ff, 3'b000};
   assign rx_id_acc     = rx_id_ff | byte_shifted;
   assign rx_length_acc = rx_length_ff | byte_shifted;
   assign field_full    = (field_cnt_ff == alra_pkg::FIELD_CNT_W'(alra_pkg::FIELD_BYTES - 1));
   assign rx_id_plus1   = rx_id_ff + alra_pkg::FIELD_W'(1);
   assign tx_id_plus1   = tx_id_ff + alra_pkg::FIELD_W'(1);
   assign idle_sat      = (idle_ticks_ff == 8'hFF) ? idle_ticks_ff : idle_ticks_ff + 8'd1;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         my_address_ff      <= 8'd0;
         auto_retransmit_ff <= 1'b0;
         rx_capacity_ff     <= alra_pkg::CAPACITY_RESET;
         timeout_ticks_ff   <= alra_pkg::TIMEOUT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            alra_pkg::CSR_MY_ADDRESS:      my_address_ff      <= csr_wdata[7:0];
            alra_pkg::CSR_AUTO_RETRANSMIT: auto_retransmit_ff <= csr_wdata[0];
            alra_pkg::CSR_RX_CAPACITY:     rx_capacity_ff     <= csr_wdata[15:0];
            alra_pkg::CSR_TIMEOUT_TICKS:   timeout_ticks_ff   <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // Next state and result of one request.
   always_comb begin
      phase_in        = phase_ff;
      ack_wait_in     = ack_wait_ff;
      field_cnt_in    = field_cnt_ff;
      rx_id_in        = rx_id_ff;
      rx_length_in    = rx_length_ff;
      payload_left_in = payload_left_ff;
      idle_ticks_in   = idle_ticks_ff;
      tx_id_in        = tx_id_ff;
      res_valid       = 1'b0;
      res_kind        = alra_pkg::EV_DATA;
      res_data        = 8'd0;
      res_last        = 1'b0;
      res_ack         = '0;

      if (req_accept) begin
         case (req_kind)
            alra_pkg::REQ_ARM: begin
               // Abandon any frame and wait for the peer's ack.
               ack_wait_in   = 1'b1;
               phase_in      = alra_pkg::PH_HUNT;
               field_cnt_in  = '0;
               idle_ticks_in = 8'd0;
            end
            alra_pkg::REQ_TICK: begin
               // Ticks count only while a frame runs or an ack is awaited.
               if (!(phase_ff == alra_pkg::PH_HUNT && !ack_wait_ff)) begin
                  idle_ticks_in = idle_sat;
                  if (idle_sat >= timeout_ticks_ff) begin
                     phase_in      = alra_pkg::PH_HUNT;
                     field_cnt_in  = '0;
                     idle_ticks_in = 8'd0;
                     res_valid     = 1'b1;
                     res_kind      = ack_wait_ff ? alra_pkg::EV_RETX
                                                 : alra_pkg::EV_TIMEOUT;
                  end
               end
            end
            alra_pkg::REQ_BYTE: begin
               idle_ticks_in = 8'd0;
               case (phase_ff)
                  alra_pkg::PH_HUNT: begin
                     if (req_ch.address_mark && req_ch.line_byte == my_address_ff) begin
                        phase_in     = ack_wait_ff ? alra_pkg::PH_ACK : alra_pkg::PH_ID;
                        field_cnt_in = '0;
                        rx_id_in     = '0;
                        rx_length_in = '0;
                     end
                  end
                  alra_pkg::PH_ID: begin
                     rx_id_in     = rx_id_acc;
                     field_cnt_in = field_full ? '0 : field_cnt_ff + 1'b1;
                     if (field_full) begin
                        phase_in = alra_pkg::PH_LEN;
                     end
                  end
                  alra_pkg::PH_LEN: begin
                     rx_length_in = rx_length_acc;
                     field_cnt_in = field_full ? '0 : field_cnt_ff + 1'b1;
                     if (field_full) begin
                        if (rx_length_acc > {{(alra_pkg::FIELD_W-16){1'b0}}, rx_capacity_ff}) begin
                           phase_in  = alra_pkg::PH_HUNT;
                           res_valid = 1'b1;
                           res_kind  = alra_pkg::EV_OVERFLOW;
                        end else if (rx_length_acc == '0) begin
                           // Empty message: ask for the ack straight away.
                           phase_in  = alra_pkg::PH_HUNT;
                           res_valid = 1'b1;
                           res_kind  = alra_pkg::EV_SEND_ACK;
                           res_ack   = rx_id_plus1;
                        end else begin
                           payload_left_in = rx_length_acc;
                           phase_in        = alra_pkg::PH_PAYLOAD;
                        end
                     end
                  end
                  alra_pkg::PH_PAYLOAD: begin
                     payload_left_in = payload_left_ff - alra_pkg::FIELD_W'(1);
                     res_valid       = 1'b1;
                     res_kind        = alra_pkg::EV_DATA;
                     res_data        = req_ch.line_byte;
                     if (payload_left_ff == alra_pkg::FIELD_W'(1)) begin
                        // The final byte also carries the ack request.
                        phase_in     = alra_pkg::PH_HUNT;
                        field_cnt_in = '0;
                        res_last     = 1'b1;
                        res_ack      = rx_id_plus1;
                     end
                  end
                  alra_pkg::PH_ACK: begin
                     rx_id_in     = rx_id_acc;
                     field_cnt_in = field_full ? '0 : field_cnt_ff + 1'b1;
                     if (field_full) begin
                        phase_in  = alra_pkg::PH_HUNT;
                        res_valid = 1'b1;
                        if (rx_id_acc == tx_id_plus1 || !auto_retransmit_ff) begin
                           tx_id_in    = tx_id_plus1;
                           ack_wait_in = 1'b0;
                           res_kind    = alra_pkg::EV_ACK_OK;
                           res_ack     = rx_id_acc;
                        end else begin
                           // Ack-wait mode stays set for the next attempt.
                           res_kind = alra_pkg::EV_RETX;
                        end
                     end
                  end
                  default: begin
                     phase_in     = alra_pkg::PH_HUNT;
                     field_cnt_in = '0;
                  end
               endcase
            end
            default: ;
         endcase
      end

      // Result register: loaded on an accepted request, cleared once taken.
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_ack_in   = rsp_ack_ff;
      if (req_accept) begin
         rsp_valid_in = res_valid;
         rsp_kind_in  = res_kind;
         rsp_data_in  = res_data;
         rsp_last_in  = res_last;
         rsp_ack_in   = res_ack;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= alra_pkg::PH_HUNT;
         ack_wait_ff     <= 1'b0;
         field_cnt_ff    <= '0;
         rx_id_ff        <= '0;
         rx_length_ff    <= '0;
         payload_left_ff <= '0;
         idle_ticks_ff   <= 8'd0;
         tx_id_ff        <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         phase_ff        <= phase_in;
         ack_wait_ff     <= ack_wait_in;
         field_cnt_ff    <= field_cnt_in;
         rx_id_ff        <= rx_id_in;
         rx_length_ff    <= rx_length_in;
         payload_left_ff <= payload_left_in;
         idle_ticks_ff   <= idle_ticks_in;
         tx_id_ff        <= tx_id_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // Result payload needs no reset.
   always_ff @(posedge clock) begin
      rsp_kind_ff <= rsp_kind_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
      rsp_ack_ff  <= rsp_ack_in;
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.event_kind = rsp_kind_ff;
   assign rsp_ch.data_byte  = rsp_data_ff;
   assign rsp_ch.last_byte  = rsp_last_ff;
   assign rsp_ch.ack_value  = rsp_ack_ff;

   // A pending result that is not being taken must hold off requests.
   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ch.ready) |-> !req_ch.ready)
      else $error("request taken while result register is blocked");

   // Only a payload byte may be marked as the last one.
   a_last_is_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_last_ff) |-> (rsp_kind_ff == alra_pkg::EV_DATA))
      else $error("last byte flag on a non-payload event");

   // The payload phase always has bytes still to come.
   a_payload_left: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == alra_pkg::PH_PAYLOAD) |-> (payload_left_ff != '0))
      else $error("payload phase with no bytes left");

   // Arming the ack wait leaves the engine hunting in ack-wait mode.
   a_arm: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_kind == alra_pkg::REQ_ARM)
      |=> (ack_wait_ff && phase_ff == alra_pkg::PH_HUNT))
      else $error("arm request did not enter ack-wait hunting");

   // An accepted ack advances the transmit id by exactly one.
   a_tx_id_step: assert property (@(posedge clock) disable iff (reset)
      (req_accept && res_valid && res_kind == alra_pkg::EV_ACK_OK)
      |=> (tx_id_ff == $past(tx_id_ff) + alra_pkg::FIELD_W'(1)))
      else $error("transmit id not advanced on accepted ack");

endmodule
`default_nettype wire
